@@ rtl/core/abst_pkg.sv @@
`default_nettype none
package abst_pkg;

   // Geometry
   localparam int BLOCK_SIZE = 256;
   localparam int FRAME_SIZE = 1024;
   localparam int COLUMNS    = 128;
   localparam int GROUP      = 8;

   // Widths
   localparam int SAMPLE_W = 12;
   localparam int ROW_W    = 8;
   localparam int FS_AW    = $clog2(FRAME_SIZE);
   localparam int COL_AW   = $clog2(COLUMNS);
   localparam int GRP_AW   = $clog2(GROUP);
   localparam int BLK_CW   = $clog2(BLOCK_SIZE + 1);
   localparam int BSUM_W   = SAMPLE_W + $clog2(BLOCK_SIZE);
   localparam int GSUM_W   = SAMPLE_W + GRP_AW;
   localparam int DC_W     = 28;
   localparam int DC_FRAC  = 16;
   localparam int MEAN_W   = BSUM_W + DC_FRAC - $clog2(BLOCK_SIZE);
   localparam int GAIN_W   = 16;
   localparam int PEAK_W   = 12;
   localparam int HALF_W   = 7;

   // DC tracker coefficients, Q0.16
   localparam int DC_KEEP  = 64225;
   localparam int DC_TAKE  = 1311;
   localparam int M1_W     = 16 + DC_W;
   localparam int M2_W     = 11 + MEAN_W;
   localparam int DCS_W    = ((M1_W > M2_W) ? M1_W : M2_W) + 1;

   // 3300/4095 reduces to 220/273
   localparam int MV_NUM   = 220;
   localparam int MV_DEN   = 273;
   localparam int K_W      = 8 + HALF_W;
   localparam int D_W      = 9 + PEAK_W;

   // Column arithmetic
   localparam int DIFF_A   = DC_W + GRP_AW;
   localparam int DIFF_B   = GSUM_W + DC_FRAC;
   localparam int DIFF_W   = ((DIFF_A > DIFF_B) ? DIFF_A : DIFF_B) + 1;
   localparam int P1_W     = DIFF_W + K_W;
   localparam int P2_W     = P1_W + GAIN_W;
   localparam int SHIFT    = GRP_AW + 24;
   localparam int REM_W    = P2_W - SHIFT + 2;
   localparam int QUO_W    = 10;
   localparam int QB_W     = $clog2(QUO_W);
   localparam int YS_W     = ROW_W + 3;

   // Reset values
   localparam logic [SAMPLE_W-1:0] SAMPLE_MID = SAMPLE_W'(2048);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(4095);
   localparam logic [ROW_W-1:0]    ROW_RESET  = ROW_W'(32);
   localparam logic [DC_W-1:0]     DC_RESET   = DC_W'(2048) << DC_FRAC;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_READ    = 2'd1,
      OP_REFRESH = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_WAVE_GAIN = 3'd0,
      CSR_PEAK_MV   = 3'd1,
      CSR_HALF      = 3'd2,
      CSR_CENTER    = 3'd3,
      CSR_TOP       = 3'd4,
      CSR_BOTTOM    = 3'd5
   } csr_index_type;

   typedef struct packed {
      op_type              op;
      logic [SAMPLE_W-1:0] sample;
      logic [COL_AW-1:0]   column;
   } item_type;

   typedef struct packed {
      logic                block_done;
      logic [SAMPLE_W-1:0] block_min;
      logic [SAMPLE_W-1:0] block_max;
      logic [SAMPLE_W-1:0] dc_value;
      logic                frame_done;
      logic [ROW_W-1:0]    column_y;
   } result_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [PEAK_W-1:0] peak;
      logic [HALF_W-1:0] half;
      logic [ROW_W-1:0]  center;
      logic [ROW_W-1:0]  top;
      logic [ROW_W-1:0]  bottom;
   } cfg_type;

   typedef struct packed {
      logic [K_W-1:0]    k;
      logic [D_W-1:0]    d;
      logic [GAIN_W-1:0] g;
      logic [ROW_W-1:0]  center;
      logic [ROW_W-1:0]  top;
      logic [ROW_W-1:0]  bottom;
   } cm_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DC_MUL,
      ST_DC_ADD,
      ST_RB_SETUP,
      ST_RB_READ,
      ST_RB_WAIT,
      ST_RB_GO,
      ST_RB_MATH,
      ST_TR_READ,
      ST_RESULT
   } back_state_type;

   typedef enum logic [2:0] {
      CM_IDLE,
      CM_MUL1,
      CM_MUL2,
      CM_PREP,
      CM_DIV,
      CM_FIN
   } cm_state_type;

endpackage
`default_nettype wire

@@ rtl/core/adc_block_stats_and_scope_trace_unit.sv @@
`default_nettype none
// ADC block statistics, DC tracker and decimating scope trace.
// Input channel (req_): push a word when full is low. operation 0 stores a
// sample, 1 reads one trace column, 2 recomputes the whole trace.
// Result channel (rsp_): one result word per input word, in order; it is
// on the ports while empty is low and leaves on pop.
// Config (csr_): write enable, register index, 16-bit data; write only while
// the block is idle. Index 0 gain, 1 peak mV, 2 half range, 3 center row,
// 4 top row, 5 bottom row.
// Sequence: the back end answers a plain sample or an ignored word directly
// and reads the trace entry first for a read; a sample that closes a block
// first runs the DC update (two multiplies then an add). A trace recompute,
// on a frame end or a refresh, has one setup step, then per column 8 frame
// store reads, a wait step, a start step for the multiply/divide unit, and
// the run of that unit.
// Reset restores control state, stats and config; unwritten frame store and
// trace entries read as their reset values, so there is no clearing pass.
// A stalled receiver fills the two-word result queue, holds one word in the
// back end, then fills the two-word input queue, after which full stays high.
module adc_block_stats_and_scope_trace_unit (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_push,
   output logic                           req_full,
   input  wire  [1:0]                     req_operation,
   input  wire  [abst_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire  [6:0]                     req_column,
   output logic                           rsp_empty,
   input  wire                            rsp_pop,
   output logic                           rsp_block_done,
   output logic [abst_pkg::SAMPLE_W-1:0]  rsp_block_min,
   output logic [abst_pkg::SAMPLE_W-1:0]  rsp_block_max,
   output logic [abst_pkg::SAMPLE_W-1:0]  rsp_dc_value,
   output logic                           rsp_frame_done,
   output logic [abst_pkg::ROW_W-1:0]     rsp_column_y,
   input  wire                            csr_we,
   input  wire  [2:0]                     csr_addr,
   input  wire  [15:0]                    csr_wdata
);

   abst_pkg::cfg_type    cfg_ff, cfg_in;
   abst_pkg::item_type   itm;
   abst_pkg::result_type res;
   logic                 itm_valid, itm_ready, res_push, res_full;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            abst_pkg::CSR_WAVE_GAIN: cfg_in.gain   = csr_wdata;
            abst_pkg::CSR_PEAK_MV:   cfg_in.peak   = csr_wdata[abst_pkg::PEAK_W-1:0];
            abst_pkg::CSR_HALF:      cfg_in.half   = csr_wdata[abst_pkg::HALF_W-1:0];
            abst_pkg::CSR_CENTER:    cfg_in.center = csr_wdata[abst_pkg::ROW_W-1:0];
            abst_pkg::CSR_TOP:       cfg_in.top    = csr_wdata[abst_pkg::ROW_W-1:0];
            abst_pkg::CSR_BOTTOM:    cfg_in.bottom = csr_wdata[abst_pkg::ROW_W-1:0];
            default:                 cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain   <= abst_pkg::GAIN_W'(256);
         cfg_ff.peak   <= abst_pkg::PEAK_W'(1650);
         cfg_ff.half   <= abst_pkg::HALF_W'(31);
         cfg_ff.center <= abst_pkg::ROW_W'(32);
         cfg_ff.top    <= abst_pkg::ROW_W'(0);
         cfg_ff.bottom <= abst_pkg::ROW_W'(63);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   abst_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_operation (req_operation),
      .req_sample    (req_sample),
      .req_column    (req_column),
      .req_full      (req_full),
      .itm_valid     (itm_valid),
      .itm_ready     (itm_ready),
      .itm           (itm)
   );

   abst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .itm_valid (itm_valid),
      .itm       (itm),
      .itm_ready (itm_ready),
      .cfg       (cfg_ff),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res)
   );

   abst_outq u_outq (
      .clock          (clock),
      .reset          (reset),
      .res_push       (res_push),
      .res            (res),
      .res_full       (res_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_block_done (rsp_block_done),
      .rsp_block_min  (rsp_block_min),
      .rsp_block_max  (rsp_block_max),
      .rsp_dc_value   (rsp_dc_value),
      .rsp_frame_done (rsp_frame_done),
      .rsp_column_y   (rsp_column_y)
   );

endmodule
`default_nettype wire

@@ rtl/core/abst_front.sv @@
`default_nettype none
module abst_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_push,
   input  wire  [1:0]                     req_operation,
   input  wire  [abst_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire  [6:0]                     req_column,
   output logic                           req_full,
   output logic                           itm_valid,
   input  wire                            itm_ready,
   output abst_pkg::item_type             itm
);

   abst_pkg::item_type itm_dec;
   abst_pkg::item_type ent_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push_ok, pop_ok;

   // Decode the incoming word; column wraps to the display width
   always_comb begin
      itm_dec.op     = abst_pkg::op_type'(req_operation);
      itm_dec.sample = req_sample;
      itm_dec.column = abst_pkg::COL_AW'(req_column);
   end

   // Two-word queue toward the back end
   always_comb begin
      req_full  = (cnt_ff == 2'd2);
      itm_valid = (cnt_ff != 2'd0);
      itm       = ent_ff[rp_ff];
      push_ok   = req_push && !req_full;
      pop_ok    = itm_valid && itm_ready;
      wp_in     = push_ok ? ~wp_ff : wp_ff;
      rp_in     = pop_ok ? ~rp_ff : rp_ff;
      cnt_in    = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         ent_ff[wp_ff] <= itm_dec;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/abst_colmath.sv @@
`default_nettype none
module abst_colmath (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire  [abst_pkg::GSUM_W-1:0]   gsum,
   input  wire  [abst_pkg::DC_W-1:0]     dc,
   input  abst_pkg::cm_cfg_type          cfg,
   output logic                          done,
   output logic [abst_pkg::ROW_W-1:0]    row
);

   abst_pkg::cm_state_type state_ff, state_in;

   logic                              neg_ff, neg_in;
   logic [abst_pkg::DIFF_W-1:0]       mag_ff, mag_in;
   logic [abst_pkg::P1_W-1:0]         p1_ff, p1_in;
   logic [abst_pkg::P2_W-1:0]         p2_ff, p2_in;
   logic [abst_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [abst_pkg::QUO_W-1:0]        quo_ff, quo_in;
   logic [abst_pkg::QB_W-1:0]         bit_ff, bit_in;

   logic signed [abst_pkg::DIFF_W-1:0] diff;
   logic [abst_pkg::REM_W-1:0]        mceil, dsh;
   logic                              lo_nz;
   logic [abst_pkg::QUO_W-2:0]        qmag;
   logic                              sat;
   logic signed [abst_pkg::QUO_W-1:0] qs;
   logic signed [abst_pkg::YS_W-1:0]  ys, ytop, ybot;

   // Row offset = floor((GROUP*dc - S*65536) * 220*half*gain / (GROUP*2^24*273*peak))
   always_comb begin
      diff  = $signed(abst_pkg::DIFF_W'(dc) << abst_pkg::GRP_AW)
            - $signed(abst_pkg::DIFF_W'(gsum) << abst_pkg::DC_FRAC);
      lo_nz = |p2_ff[abst_pkg::SHIFT-1:0];
      mceil = abst_pkg::REM_W'(p2_ff >> abst_pkg::SHIFT)
            + abst_pkg::REM_W'(neg_ff && lo_nz);
      dsh   = abst_pkg::REM_W'(cfg.d) << bit_ff;

      // Saturated quotient: top bit set means the row is off screen anyway
      qmag = quo_ff[abst_pkg::QUO_W-2:0];
      sat  = quo_ff[abst_pkg::QUO_W-1];
      if (neg_ff) begin
         qs = sat ? {1'b1, {(abst_pkg::QUO_W-1){1'b0}}} : -$signed({1'b0, qmag});
      end else begin
         qs = sat ? {1'b0, {(abst_pkg::QUO_W-1){1'b1}}} : $signed({1'b0, qmag});
      end
      ys   = $signed({3'b000, cfg.center})
           + {{(abst_pkg::YS_W-abst_pkg::QUO_W){qs[abst_pkg::QUO_W-1]}}, qs};
      ytop = $signed({3'b000, cfg.top});
      ybot = $signed({3'b000, cfg.bottom});
      if (ys < ytop) begin
         ys = ytop;
      end
      if (ys > ybot) begin
         ys = ybot;
      end
      row  = abst_pkg::ROW_W'(ys);
      done = (state_ff == abst_pkg::CM_FIN);
   end

   // Sequencer: two multiplies, rounding prep, one quotient bit per cycle
   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      case (state_ff)
         abst_pkg::CM_IDLE: begin
            if (start) begin
               neg_in   = diff[abst_pkg::DIFF_W-1];
               mag_in   = diff[abst_pkg::DIFF_W-1] ? abst_pkg::DIFF_W'(-diff)
                                                   : abst_pkg::DIFF_W'(diff);
               state_in = abst_pkg::CM_MUL1;
            end
         end
         abst_pkg::CM_MUL1: begin
            p1_in    = abst_pkg::P1_W'(mag_ff) * abst_pkg::P1_W'(cfg.k);
            state_in = abst_pkg::CM_MUL2;
         end
         abst_pkg::CM_MUL2: begin
            p2_in    = abst_pkg::P2_W'(p1_ff) * abst_pkg::P2_W'(cfg.g);
            state_in = abst_pkg::CM_PREP;
         end
         abst_pkg::CM_PREP: begin
            // negative side rounds toward minus infinity: divide the ceiling up
            rem_in   = neg_ff ? mceil + abst_pkg::REM_W'(cfg.d) - abst_pkg::REM_W'(1)
                              : mceil;
            quo_in   = '0;
            bit_in   = abst_pkg::QB_W'(abst_pkg::QUO_W - 1);
            state_in = abst_pkg::CM_DIV;
         end
         abst_pkg::CM_DIV: begin
            if (rem_ff >= dsh) begin
               rem_in         = rem_ff - dsh;
               quo_in[bit_ff] = 1'b1;
            end
            if (bit_ff == '0) begin
               state_in = abst_pkg::CM_FIN;
            end else begin
               bit_in = bit_ff - abst_pkg::QB_W'(1);
            end
         end
         abst_pkg::CM_FIN: begin
            state_in = abst_pkg::CM_IDLE;
         end
         default: begin
            state_in = abst_pkg::CM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abst_pkg::CM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/abst_back.sv @@
`default_nettype none
module abst_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   itm_valid,
   input  abst_pkg::item_type    itm,
   output logic                  itm_ready,
   input  abst_pkg::cfg_type     cfg,
   input  wire                   res_full,
   output logic                  res_push,
   output abst_pkg::result_type  res
);

   abst_pkg::back_state_type state_ff, state_in;

   logic [abst_pkg::FS_AW-1:0]    pos_ff, pos_in;
   logic                          wrap_ff, wrap_in;
   logic [abst_pkg::BLK_CW-1:0]   cnt_ff, cnt_in;
   logic [abst_pkg::BSUM_W-1:0]   sum_ff, sum_in;
   logic [abst_pkg::SAMPLE_W-1:0] rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic [abst_pkg::SAMPLE_W-1:0] hmin_ff, hmin_in, hmax_ff, hmax_in;
   logic [abst_pkg::DC_W-1:0]     dc_ff, dc_in;
   logic                          fpend_ff, fpend_in;
   logic                          bdone_ff, bdone_in, fdone_ff, fdone_in;
   logic [abst_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [abst_pkg::COL_AW-1:0]   rcol_ff, rcol_in;
   logic [abst_pkg::M1_W-1:0]     m1_ff, m1_in;
   logic [abst_pkg::M2_W-1:0]     m2_ff, m2_in;
   logic [abst_pkg::K_W-1:0]      k_ff, k_in;
   logic [abst_pkg::D_W-1:0]      d_ff, d_in;
   logic [abst_pkg::COL_AW-1:0]   col_ff, col_in;
   logic [abst_pkg::GRP_AW-1:0]   kk_ff, kk_in;
   logic [abst_pkg::GSUM_W-1:0]   acc_ff, acc_in;
   logic                          rd_vld_ff, fs_ok_ff;
   logic [abst_pkg::SAMPLE_W-1:0] fs_rdata_ff;
   logic [abst_pkg::ROW_W-1:0]    tr_rdata_ff;
   logic [abst_pkg::COLUMNS-1:0]  tr_valid_ff;

   logic [abst_pkg::SAMPLE_W-1:0] fs_mem [abst_pkg::FRAME_SIZE];
   logic [abst_pkg::ROW_W-1:0]    tr_mem [abst_pkg::COLUMNS];

   logic                          fs_we, tr_we, cm_start, cm_done;
   logic [abst_pkg::FS_AW-1:0]    fs_raddr;
   logic [abst_pkg::FS_AW:0]      pos_inc;
   logic [abst_pkg::BLK_CW-1:0]   cnt_inc;
   logic [abst_pkg::SAMPLE_W-1:0] new_min, new_max, eff;
   logic [abst_pkg::BSUM_W+abst_pkg::DC_FRAC-1:0] sum_sh;
   logic [abst_pkg::MEAN_W-1:0]   mean;
   logic [abst_pkg::DCS_W-1:0]    dcsum;
   logic [abst_pkg::PEAK_W-1:0]   peak_eff;
   logic [abst_pkg::ROW_W-1:0]    cm_row;
   abst_pkg::cm_cfg_type          cm_cfg;

   // Column math unit
   always_comb begin
      cm_cfg.k      = k_ff;
      cm_cfg.d      = d_ff;
      cm_cfg.g      = cfg.gain;
      cm_cfg.center = cfg.center;
      cm_cfg.top    = cfg.top;
      cm_cfg.bottom = cfg.bottom;
   end

   abst_colmath u_colmath (
      .clock (clock),
      .reset (reset),
      .start (cm_start),
      .gsum  (acc_ff),
      .dc    (dc_ff),
      .cfg   (cm_cfg),
      .done  (cm_done),
      .row   (cm_row)
   );

   // Datapath helpers
   always_comb begin
      fs_raddr = abst_pkg::FS_AW'({col_ff, kk_ff});
      pos_inc  = {1'b0, pos_ff} + (abst_pkg::FS_AW+1)'(1);
      cnt_inc  = cnt_ff + abst_pkg::BLK_CW'(1);
      new_min  = (itm.sample < rmin_ff) ? itm.sample : rmin_ff;
      new_max  = (itm.sample > rmax_ff) ? itm.sample : rmax_ff;
      eff      = fs_ok_ff ? fs_rdata_ff : abst_pkg::SAMPLE_MID;
      sum_sh   = {sum_ff, {abst_pkg::DC_FRAC{1'b0}}};
      mean     = abst_pkg::MEAN_W'(sum_sh / abst_pkg::BLOCK_SIZE);
      dcsum    = abst_pkg::DCS_W'(m1_ff) + abst_pkg::DCS_W'(m2_ff);
      peak_eff = (cfg.peak == '0) ? abst_pkg::PEAK_W'(1) : cfg.peak;

      res.block_done = bdone_ff;
      res.block_min  = hmin_ff;
      res.block_max  = hmax_ff;
      res.dc_value   = dc_ff[abst_pkg::DC_FRAC +: abst_pkg::SAMPLE_W];
      res.frame_done = fdone_ff;
      res.column_y   = row_ff;
   end

   // Control sequencer
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      wrap_in   = wrap_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      rmin_in   = rmin_ff;
      rmax_in   = rmax_ff;
      hmin_in   = hmin_ff;
      hmax_in   = hmax_ff;
      dc_in     = dc_ff;
      fpend_in  = fpend_ff;
      bdone_in  = bdone_ff;
      fdone_in  = fdone_ff;
      row_in    = row_ff;
      rcol_in   = rcol_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      k_in      = k_ff;
      d_in      = d_ff;
      col_in    = col_ff;
      kk_in     = kk_ff;
      acc_in    = rd_vld_ff ? acc_ff + abst_pkg::GSUM_W'(eff) : acc_ff;
      itm_ready = 1'b0;
      res_push  = 1'b0;
      cm_start  = 1'b0;
      fs_we     = 1'b0;
      tr_we     = 1'b0;
      case (state_ff)
         abst_pkg::ST_IDLE: begin
            if (itm_valid) begin
               itm_ready = 1'b1;
               bdone_in  = 1'b0;
               fdone_in  = 1'b0;
               row_in    = '0;
               rcol_in   = itm.column;
               case (itm.op)
                  abst_pkg::OP_SAMPLE: begin
                     fs_we    = 1'b1;
                     sum_in   = sum_ff + abst_pkg::BSUM_W'(itm.sample);
                     rmin_in  = new_min;
                     rmax_in  = new_max;
                     cnt_in   = cnt_inc;
                     state_in = abst_pkg::ST_RESULT;
                     if (pos_inc == (abst_pkg::FS_AW+1)'(abst_pkg::FRAME_SIZE)) begin
                        pos_in   = '0;
                        wrap_in  = 1'b1;
                        fpend_in = 1'b1;
                        state_in = abst_pkg::ST_RB_SETUP;
                     end else begin
                        pos_in = pos_inc[abst_pkg::FS_AW-1:0];
                     end
                     // block close: DC update runs before any trace rebuild
                     if (cnt_inc == abst_pkg::BLK_CW'(abst_pkg::BLOCK_SIZE)) begin
                        hmin_in  = new_min;
                        hmax_in  = new_max;
                        rmin_in  = abst_pkg::SAMPLE_MAX;
                        rmax_in  = '0;
                        cnt_in   = '0;
                        bdone_in = 1'b1;
                        state_in = abst_pkg::ST_DC_MUL;
                     end
                  end
                  abst_pkg::OP_READ: begin
                     state_in = abst_pkg::ST_TR_READ;
                  end
                  abst_pkg::OP_REFRESH: begin
                     state_in = abst_pkg::ST_RB_SETUP;
                  end
                  default: begin
                     state_in = abst_pkg::ST_RESULT;
                  end
               endcase
            end
         end
         abst_pkg::ST_DC_MUL: begin
            m1_in    = abst_pkg::M1_W'(dc_ff) * abst_pkg::M1_W'(abst_pkg::DC_KEEP);
            m2_in    = abst_pkg::M2_W'(mean) * abst_pkg::M2_W'(abst_pkg::DC_TAKE);
            sum_in   = '0;
            state_in = abst_pkg::ST_DC_ADD;
         end
         abst_pkg::ST_DC_ADD: begin
            dc_in    = dcsum[abst_pkg::DC_FRAC +: abst_pkg::DC_W];
            state_in = fpend_ff ? abst_pkg::ST_RB_SETUP : abst_pkg::ST_RESULT;
         end
         abst_pkg::ST_RB_SETUP: begin
            fpend_in = 1'b0;
            fdone_in = 1'b1;
            k_in     = abst_pkg::K_W'(cfg.half) * abst_pkg::K_W'(abst_pkg::MV_NUM);
            d_in     = abst_pkg::D_W'(peak_eff) * abst_pkg::D_W'(abst_pkg::MV_DEN);
            col_in   = '0;
            kk_in    = '0;
            acc_in   = '0;
            state_in = abst_pkg::ST_RB_READ;
         end
         abst_pkg::ST_RB_READ: begin
            if (kk_ff == abst_pkg::GRP_AW'(abst_pkg::GROUP - 1)) begin
               kk_in    = '0;
               state_in = abst_pkg::ST_RB_WAIT;
            end else begin
               kk_in = kk_ff + abst_pkg::GRP_AW'(1);
            end
         end
         abst_pkg::ST_RB_WAIT: begin
            state_in = abst_pkg::ST_RB_GO;
         end
         abst_pkg::ST_RB_GO: begin
            cm_start = 1'b1;
            state_in = abst_pkg::ST_RB_MATH;
         end
         abst_pkg::ST_RB_MATH: begin
            if (cm_done) begin
               tr_we  = 1'b1;
               acc_in = '0;
               if (col_ff == abst_pkg::COL_AW'(abst_pkg::COLUMNS - 1)) begin
                  state_in = abst_pkg::ST_RESULT;
               end else begin
                  col_in   = col_ff + abst_pkg::COL_AW'(1);
                  state_in = abst_pkg::ST_RB_READ;
               end
            end
         end
         abst_pkg::ST_TR_READ: begin
            row_in   = tr_valid_ff[rcol_ff] ? tr_rdata_ff : abst_pkg::ROW_RESET;
            state_in = abst_pkg::ST_RESULT;
         end
         abst_pkg::ST_RESULT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = abst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abst_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= abst_pkg::ST_IDLE;
         pos_ff      <= '0;
         wrap_ff     <= 1'b0;
         cnt_ff      <= '0;
         sum_ff      <= '0;
         rmin_ff     <= abst_pkg::SAMPLE_MAX;
         rmax_ff     <= '0;
         hmin_ff     <= abst_pkg::SAMPLE_MAX;
         hmax_ff     <= '0;
         dc_ff       <= abst_pkg::DC_RESET;
         fpend_ff    <= 1'b0;
         rd_vld_ff   <= 1'b0;
         tr_valid_ff <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         wrap_ff   <= wrap_in;
         cnt_ff    <= cnt_in;
         sum_ff    <= sum_in;
         rmin_ff   <= rmin_in;
         rmax_ff   <= rmax_in;
         hmin_ff   <= hmin_in;
         hmax_ff   <= hmax_in;
         dc_ff     <= dc_in;
         fpend_ff  <= fpend_in;
         rd_vld_ff <= (state_ff == abst_pkg::ST_RB_READ);
         if (tr_we) begin
            tr_valid_ff[col_ff] <= 1'b1;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      bdone_ff <= bdone_in;
      fdone_ff <= fdone_in;
      row_ff   <= row_in;
      rcol_ff  <= rcol_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      k_ff     <= k_in;
      d_ff     <= d_in;
      col_ff   <= col_in;
      kk_ff    <= kk_in;
      acc_ff   <= acc_in;
      // entries not yet written since reset read as mid-scale
      fs_ok_ff <= wrap_ff || (fs_raddr < pos_ff);
   end

   // Frame store
   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[pos_ff] <= itm.sample;
      end
      fs_rdata_ff <= fs_mem[fs_raddr];
   end

   // Trace rows
   always_ff @(posedge clock) begin
      if (tr_we) begin
         tr_mem[col_ff] <= cm_row;
      end
      tr_rdata_ff <= tr_mem[itm.column];
   end

endmodule
`default_nettype wire

@@ rtl/core/abst_outq.sv @@
`default_nettype none
module abst_outq (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            res_push,
   input  abst_pkg::result_type           res,
   output logic                           res_full,
   output logic                           rsp_empty,
   input  wire                            rsp_pop,
   output logic                           rsp_block_done,
   output logic [abst_pkg::SAMPLE_W-1:0]  rsp_block_min,
   output logic [abst_pkg::SAMPLE_W-1:0]  rsp_block_max,
   output logic [abst_pkg::SAMPLE_W-1:0]  rsp_dc_value,
   output logic                           rsp_frame_done,
   output logic [abst_pkg::ROW_W-1:0]     rsp_column_y
);

   abst_pkg::result_type ent_ff [2];
   abst_pkg::result_type head;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push_ok, pop_ok;

   // Two-word result queue
   always_comb begin
      res_full       = (cnt_ff == 2'd2);
      rsp_empty      = (cnt_ff == 2'd0);
      head           = ent_ff[rp_ff];
      rsp_block_done = head.block_done;
      rsp_block_min  = head.block_min;
      rsp_block_max  = head.block_max;
      rsp_dc_value   = head.dc_value;
      rsp_frame_done = head.frame_done;
      rsp_column_y   = head.column_y;
      push_ok        = res_push && !res_full;
      pop_ok         = rsp_pop && !rsp_empty;
      wp_in          = push_ok ? ~wp_ff : wp_ff;
      rp_in          = pop_ok ? ~rp_ff : rp_ff;
      cnt_in         = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         ent_ff[wp_ff] <= res;
      end
   end

endmodule
`default_nettype wire
